/* rtl/radix_number_lexer_defines.svh */
// ---------------------------------------------------------------------------
// Radix number lexer assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RADIX_NUMBER_LEXER_DEFINES_SVH
`define RADIX_NUMBER_LEXER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define RNL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("radix_number_lexer: assertion failed");
// Next-cycle implication, checked outside reset.
`define RNL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("radix_number_lexer: assertion failed");
`else
`define RNL_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define RNL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/rnl_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix number lexer package
// Shared types, character codes and the digit decoder.
// ---------------------------------------------------------------------------
package rnl_pkg;

   localparam int CNT_W = 16;
   localparam logic [CNT_W-1:0] MAX_LEN = 16'hFFFF;

   localparam logic [5:0] RADIX_MIN   = 6'd2;
   localparam logic [5:0] RADIX_MAX   = 6'd36;
   localparam logic [5:0] RADIX_RESET = 6'd10;

   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_LEAD_US   = 2'd1,
      ERR_NO_DIGITS = 2'd2,
      ERR_TRAIL_US  = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      PH_SIGN   = 3'b001,
      PH_ZEROS  = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

   typedef struct packed {
      logic             is_end;
      logic [5:0]       digit_value;
      logic             negative;
      err_type          error_code;
      logic [CNT_W-1:0] consumed_count;
      logic             last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } step_out_type;

   // Returns {valid, value}; letters of either case map to 10..35.
   function automatic logic [6:0] char_digit(input logic [7:0] c);
      logic [7:0] v;
      logic       ok;
      begin
         v  = 8'd0;
         ok = 1'b0;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            v  = c - CH_ZERO;
            ok = 1'b1;
         end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v  = c - CH_LOWER_A + 8'd10;
            ok = 1'b1;
         end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v  = c - CH_UPPER_A + 8'd10;
            ok = 1'b1;
         end
         return {ok, v[5:0]};
      end
   endfunction

endpackage

/* rtl/rnl_step_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix number lexer step core
// Lexer state registers and the single-pass next-state and result logic.
// ---------------------------------------------------------------------------
module rnl_step_core
   import rnl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [5:0]   radix,
   input  logic [7:0]   char_in,
   input  logic         fire,
   output step_out_type step_out
);

   phase_type        phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic             zp_ff, zp_in;
   logic             sd_ff, sd_in;
   logic             pu_ff, pu_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [5:0]       base;
   logic [6:0]       dig;
   logic [CNT_W-1:0] bumped;
   logic             go_zero, go_digit, do_end, zero_emit, seen;
   rsp_type          end_res;

   assign base   = (radix < RADIX_MIN) ? RADIX_MIN :
                   ((radix > RADIX_MAX) ? RADIX_MAX : radix);
   assign dig    = char_digit(char_in);
   assign bumped = (cnt_ff < MAX_LEN) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      zp_in     = zp_ff;
      sd_in     = sd_ff;
      pu_in     = pu_ff;
      cnt_in    = cnt_ff;
      go_zero   = 1'b0;
      go_digit  = 1'b0;
      do_end    = 1'b0;
      zero_emit = 1'b0;
      seen      = 1'b0;
      end_res   = '0;
      step_out  = '0;

      unique case (phase_ff)
         PH_SIGN: begin
            if (char_in == CH_PLUS || char_in == CH_MINUS) begin
               neg_in = neg_ff ^ (char_in == CH_MINUS);
               cnt_in = bumped;
            end else if (char_in == CH_UNDERSCORE) begin
               step_out.count                = 2'd1;
               step_out.res0.is_end          = 1'b1;
               step_out.res0.negative        = neg_ff;
               step_out.res0.error_code      = ERR_LEAD_US;
               step_out.res0.consumed_count  = cnt_ff;
               step_out.res0.last_of_run     = 1'b1;
               phase_in = PH_SIGN;
               neg_in   = 1'b0;
               zp_in    = 1'b0;
               sd_in    = 1'b0;
               pu_in    = 1'b0;
               cnt_in   = '0;
            end else begin
               go_zero = 1'b1;
            end
         end
         PH_ZEROS:  go_zero  = 1'b1;
         PH_DIGITS: go_digit = 1'b1;
         default:   go_digit = 1'b1;
      endcase

      if (go_zero) begin
         if (char_in == CH_ZERO) begin
            cnt_in   = bumped;
            zp_in    = 1'b1;
            phase_in = PH_ZEROS;
         end else if (char_in == CH_NUL && zp_ff) begin
            // A run of zeros up to NUL still stands for the number zero.
            zero_emit = 1'b1;
            do_end    = 1'b1;
         end else begin
            go_digit = 1'b1;
         end
      end

      if (go_digit) begin
         if (char_in == CH_UNDERSCORE) begin
            cnt_in   = bumped;
            pu_in    = 1'b1;
            phase_in = PH_DIGITS;
         end else if (dig[6] && dig[5:0] < base) begin
            cnt_in   = bumped;
            sd_in    = 1'b1;
            pu_in    = 1'b0;
            phase_in = PH_DIGITS;
            step_out.count             = 2'd1;
            step_out.res0.digit_value  = dig[5:0];
            step_out.res0.last_of_run  = 1'b1;
         end else begin
            do_end = 1'b1;
         end
      end

      if (do_end) begin
         seen                   = sd_ff | zero_emit;
         end_res.is_end         = 1'b1;
         end_res.negative       = neg_ff;
         end_res.last_of_run    = 1'b1;
         end_res.consumed_count = cnt_ff;
         if (!seen) begin
            end_res.error_code = ERR_NO_DIGITS;
         end else if (pu_ff) begin
            end_res.error_code = ERR_TRAIL_US;
            if (cnt_ff != '0) begin
               end_res.consumed_count = cnt_ff - 1'b1;
            end
         end else begin
            end_res.error_code = ERR_OK;
         end
         if (zero_emit) begin
            step_out.count = 2'd2;
            step_out.res0  = '0;
            step_out.res1  = end_res;
         end else begin
            step_out.count = 2'd1;
            step_out.res0  = end_res;
         end
         phase_in = PH_SIGN;
         neg_in   = 1'b0;
         zp_in    = 1'b0;
         sd_in    = 1'b0;
         pu_in    = 1'b0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIGN;
         neg_ff   <= 1'b0;
         zp_ff    <= 1'b0;
         sd_ff    <= 1'b0;
         pu_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         zp_ff    <= zp_in;
         sd_ff    <= sd_in;
         pu_ff    <= pu_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/rnl_rsp_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix number lexer result queue
// Two-entry result buffer that takes up to two results per cycle.
// ---------------------------------------------------------------------------
module rnl_rsp_queue
   import rnl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  rsp_type    push0,
   input  rsp_type    push1,
   input  logic       pop,
   output rsp_type    head,
   output logic       head_valid,
   output logic [1:0] fill
);

   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   rsp_type    keep0;
   logic [1:0] kept;

   // The producer never pushes more than the free space counted without pop.
   always_comb begin
      keep0 = pop ? slot1_ff : slot0_ff;
      kept  = count_ff - {1'b0, pop};
      unique case (kept)
         2'd0: begin
            slot0_in = push0;
            slot1_in = push1;
         end
         2'd1: begin
            slot0_in = keep0;
            slot1_in = push0;
         end
         default: begin
            slot0_in = keep0;
            slot1_in = slot1_ff;
         end
      endcase
      count_in = kept + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head       = slot0_ff;
   assign head_valid = (count_ff != 2'd0);
   assign fill       = count_ff;

endmodule

/* rtl/radix_number_lexer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix number lexer
// Lexes signed numbers in a configurable radix from a character stream.
// ---------------------------------------------------------------------------
// Characters arrive one per transfer on the req_ channel. Each character
// yields zero, one or two results on the rsp_ channel: a digit result per
// accepted digit and an end result with sign, error code and count when a
// number ends. A run of zeros ended by NUL gives a zero digit and the end
// result from the same character. csr_wr_en writes the radix (reset 10);
// write it only while the block is idle.
// A character is held in an input register, runs through one pass of lexer
// logic and its results land in a two-entry result queue, so the first
// result of a character shows on rsp_valid once the queue has registered
// it. One character is taken per cycle while the queue has room for its
// results; a character that gives two results waits until the queue is
// empty.
// When the receiver stalls, the queue fills and req_ready drops after the
// input register is also occupied. Synchronous reset empties the pipeline,
// restores radix 10 and starts a fresh number.
// ---------------------------------------------------------------------------
`include "radix_number_lexer_defines.svh"

module radix_number_lexer
   import rnl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_end,
   output logic [5:0]  rsp_digit_value,
   output logic        rsp_negative,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_consumed_count,
   output logic        rsp_last_of_run
);

   logic [5:0]   radix_ff;
   logic [7:0]   char_ff;
   logic         in_vld_ff;
   logic         fire;
   logic [1:0]   q_fill;
   logic [1:0]   free_slots;
   step_out_type step_out;
   rsp_type      q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_wr_en) begin
         radix_ff <= csr_wr_data;
      end
   end

   assign free_slots = 2'd2 - q_fill;
   assign fire       = in_vld_ff && (step_out.count <= free_slots);
   assign req_ready  = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_in;
      end
   end

   rnl_step_core u_core (
      .clock    (clock),
      .reset    (reset),
      .radix    (radix_ff),
      .char_in  (char_ff),
      .fire     (fire),
      .step_out (step_out)
   );

   rnl_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (fire ? step_out.count : 2'd0),
      .push0      (step_out.res0),
      .push1      (step_out.res1),
      .pop        (rsp_valid && rsp_ready),
      .head       (q_head),
      .head_valid (rsp_valid),
      .fill       (q_fill)
   );

   assign rsp_is_end         = q_head.is_end;
   assign rsp_digit_value    = q_head.digit_value;
   assign rsp_negative       = q_head.negative;
   assign rsp_error_code     = q_head.error_code;
   assign rsp_consumed_count = q_head.consumed_count;
   assign rsp_last_of_run    = q_head.last_of_run;

   `RNL_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, q_fill <= 2'd2)
   `RNL_ASSERT_SAME(a_digit_clean, clock, reset, rsp_valid && !rsp_is_end,
      (rsp_error_code == ERR_OK) && !rsp_negative && (rsp_consumed_count == '0)
      && (rsp_digit_value < RADIX_MAX))
   `RNL_ASSERT_SAME(a_pair_order, clock, reset, fire && (step_out.count == 2'd2),
      !step_out.res0.is_end && !step_out.res0.last_of_run
      && step_out.res1.is_end && step_out.res1.last_of_run)
   `RNL_ASSERT_NEXT(a_pair_lands, clock, reset, fire && (step_out.count == 2'd2),
      rsp_valid && !rsp_is_end && (q_fill == 2'd2))

endmodule
